>>> hdl/overlay_pixel_blend_restore_top_macros.svh
// assertion macros used by the checker file opbr_check.sv
`ifndef OVERLAY_PIXEL_BLEND_RESTORE_TOP_MACROS_SVH
`define OVERLAY_PIXEL_BLEND_RESTORE_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define OPBR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define OPBR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/opbr_pkg.sv
package opbr_pkg;

	localparam int FRAME_COLS_DEF = 256;
	localparam int FRAME_ROWS_DEF = 256;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

	localparam logic [8:0] FRAME_SIZE_RST = 9'd256;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;
	localparam logic [7:0] ALPHA_CLEAR    = 8'd0;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// floor(x / 255), exact for every product of two 8-bit values
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

>>> hdl/overlay_pixel_blend_restore_top.sv
// channel   signals                                            direction  timing
// item      start busy mode pos_x pos_y source_* buffer_*      in         taken on start & !busy
// result    done write_enable write_x write_y out_*            out        one cycle, done high
// config    cfg_write cfg_index cfg_data                       in         taken on cfg_write
//
// an item runs address, memory read, multiply and write-back steps: busy stays high
// from when it is taken until write-back ends, so the next item waits for write-back
// done is high in the cycle after write-back; the next item can be taken at its closing edge
// after reset both stores are swept to zero, all FRAME_COLS * FRAME_ROWS addresses (65536 at
// the defaults), with busy high; config writes are taken during the sweep
// the receiver cannot stall: done is a one-cycle strobe
module overlay_pixel_blend_restore_top #(
	parameter int FRAME_COLS = opbr_pkg::FRAME_COLS_DEF,
	parameter int FRAME_ROWS = opbr_pkg::FRAME_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            mode,
	input  logic [11:0]                     pos_x,
	input  logic [11:0]                     pos_y,
	input  logic [7:0]                      source_red,
	input  logic [7:0]                      source_green,
	input  logic [7:0]                      source_blue,
	input  logic [7:0]                      source_alpha,
	input  logic [7:0]                      buffer_red,
	input  logic [7:0]                      buffer_green,
	input  logic [7:0]                      buffer_blue,
	output logic                            done,
	output logic                            write_enable,
	output logic [7:0]                      write_x,
	output logic [7:0]                      write_y,
	output logic [7:0]                      out_red,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_blue,
	input  logic                            cfg_write,
	input  logic [opbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [opbr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = FRAME_COLS * FRAME_ROWS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_ADDR  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t state_q;

	logic [8:0]  frame_width_q, frame_height_q;
	logic [11:0] origin_x_q, origin_y_q, image_width_q, image_height_q;

	logic           mode_q;
	logic [11:0]    pos_x_q, pos_y_q;
	opbr_pkg::pix_t src_q, buf_q;
	logic [7:0]     alpha_q;

	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] idx_q;
	logic          hit_q;
	logic [7:0]    wx_q, wy_q;

	logic [12:0] cx, cy;
	logic [13:0] fw, fh;
	logic        in_img, in_frm, hit;
	logic [31:0] idx_full;

	opbr_pkg::pix_t saved_rd, drawn_rd, cov, blend_pix, new_pix, emit_pix;
	logic           emit;
	logic           drawn_we, saved_we, mem_we_d, mem_we_s;
	opbr_pkg::pix_t drawn_wd, saved_wd, mem_wd_d, mem_wd_s;
	logic [AW-1:0]  mem_waddr;
	logic           clear_op;

	logic       done_q, write_enable_q;
	logic [7:0] write_x_q, write_y_q;
	opbr_pkg::pix_t out_pix_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= opbr_pkg::FRAME_SIZE_RST;
			frame_height_q <= opbr_pkg::FRAME_SIZE_RST;
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			image_width_q  <= '0;
			image_height_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				opbr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[8:0];
				opbr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[8:0];
				opbr_pkg::REG_ORIGIN_X:     origin_x_q     <= cfg_data;
				opbr_pkg::REG_ORIGIN_Y:     origin_y_q     <= cfg_data;
				opbr_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				opbr_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE:  if (start) state_q <= ST_ADDR;
				ST_ADDR:  state_q <= ST_READ;
				ST_READ:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_WRITE;
				ST_WRITE: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	// item capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_q    <= mode;
			pos_x_q   <= pos_x;
			pos_y_q   <= pos_y;
			src_q     <= '{red: source_red, green: source_green, blue: source_blue};
			alpha_q   <= source_alpha;
			buf_q     <= '{red: buffer_red, green: buffer_green, blue: buffer_blue};
		end
	end

	// frame position and bounds
	always_comb begin
		if (mode_q) begin
			cx = {1'b0, pos_x_q};
			cy = {1'b0, pos_y_q};
		end else begin
			cx = {1'b0, pos_x_q} + {1'b0, origin_x_q};
			cy = {1'b0, pos_y_q} + {1'b0, origin_y_q};
		end
		fw = (14'(frame_width_q) > 14'(FRAME_COLS)) ? 14'(FRAME_COLS) : 14'(frame_width_q);
		fh = (14'(frame_height_q) > 14'(FRAME_ROWS)) ? 14'(FRAME_ROWS) : 14'(frame_height_q);
		in_img = (pos_x_q < image_width_q) && (pos_y_q < image_height_q);
		in_frm = ({1'b0, cx} < fw) && ({1'b0, cy} < fh);
		hit = in_frm && (mode_q || in_img);
		idx_full = 32'(cy) * 32'(FRAME_COLS) + 32'(cx);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			hit_q <= hit;
			idx_q <= hit ? idx_full[AW-1:0] : '0;
			wx_q  <= cx[7:0];
			wy_q  <= cy[7:0];
		end
	end

	// stores
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : idx_q;
	assign mem_we_d  = (state_q == ST_CLEAR) || drawn_we;
	assign mem_we_s  = (state_q == ST_CLEAR) || saved_we;
	assign mem_wd_d  = (state_q == ST_CLEAR) ? '0 : drawn_wd;
	assign mem_wd_s  = (state_q == ST_CLEAR) ? '0 : saved_wd;

	opbr_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    ($bits(opbr_pkg::pix_t))
	) u_drawn (
		.clk   (clk),
		.we    (mem_we_d),
		.waddr (mem_waddr),
		.wdata (mem_wd_d),
		.re    (state_q == ST_READ),
		.raddr (idx_q),
		.rdata (drawn_rd)
	);

	opbr_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    ($bits(opbr_pkg::pix_t))
	) u_saved (
		.clk   (clk),
		.we    (mem_we_s),
		.waddr (mem_waddr),
		.wdata (mem_wd_s),
		.re    (state_q == ST_READ),
		.raddr (idx_q),
		.rdata (saved_rd)
	);

	// black saved pixel means nothing saved
	assign cov = (saved_rd != '0) ? saved_rd : buf_q;

	opbr_blend u_blend (
		.clk       (clk),
		.en        (state_q == ST_MUL),
		.src       (src_q),
		.cov       (cov),
		.alpha     (alpha_q),
		.blend_pix (blend_pix)
	);

	// write-back decision
	always_comb begin
		clear_op = mode_q || (alpha_q == opbr_pkg::ALPHA_CLEAR);
		new_pix  = (alpha_q == opbr_pkg::ALPHA_OPAQUE) ? src_q : blend_pix;
		emit     = 1'b0;
		emit_pix = '0;
		drawn_we = 1'b0;
		saved_we = 1'b0;
		drawn_wd = '0;
		saved_wd = '0;
		if (state_q == ST_WRITE && hit_q) begin
			if (clear_op) begin
				if (saved_rd != '0) begin
					drawn_we = 1'b1;
					saved_we = 1'b1;
					emit     = (drawn_rd == buf_q);
					emit_pix = (drawn_rd == buf_q) ? saved_rd : '0;
				end
			end else if (new_pix != buf_q) begin
				drawn_we = 1'b1;
				drawn_wd = new_pix;
				saved_we = (drawn_rd != buf_q);
				saved_wd = buf_q;
				emit     = 1'b1;
				emit_pix = new_pix;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			write_enable_q <= emit;
			write_x_q      <= emit ? wx_q : '0;
			write_y_q      <= emit ? wy_q : '0;
			out_pix_q      <= emit_pix;
		end
	end

	assign done         = done_q;
	assign write_enable = write_enable_q;
	assign write_x      = write_x_q;
	assign write_y      = write_y_q;
	assign out_red      = out_pix_q.red;
	assign out_green    = out_pix_q.green;
	assign out_blue     = out_pix_q.blue;

endmodule

>>> hdl/opbr_ram.sv
module opbr_ram #(
	parameter int DEPTH = 65536,
	parameter int AW = 16,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/opbr_blend.sv
module opbr_blend (
	input  logic             clk,
	input  logic             en,
	input  opbr_pkg::pix_t   src,
	input  opbr_pkg::pix_t   cov,
	input  logic [7:0]       alpha,
	output opbr_pkg::pix_t   blend_pix
);

	logic [7:0]  inv_alpha;
	logic [15:0] prod_src_s1 [3];
	logic [15:0] prod_cov_s1 [3];
	logic [8:0]  sum_r, sum_g, sum_b;

	assign inv_alpha = opbr_pkg::ALPHA_OPAQUE - alpha;

	// one register stage after the multipliers
	always_ff @(posedge clk) begin
		if (en) begin
			prod_src_s1[0] <= src.red   * alpha;
			prod_src_s1[1] <= src.green * alpha;
			prod_src_s1[2] <= src.blue  * alpha;
			prod_cov_s1[0] <= cov.red   * inv_alpha;
			prod_cov_s1[1] <= cov.green * inv_alpha;
			prod_cov_s1[2] <= cov.blue  * inv_alpha;
		end
	end

	// each term truncated on its own, the sum never passes 255
	always_comb begin
		sum_r = 9'(opbr_pkg::div255(prod_src_s1[0])) + 9'(opbr_pkg::div255(prod_cov_s1[0]));
		sum_g = 9'(opbr_pkg::div255(prod_src_s1[1])) + 9'(opbr_pkg::div255(prod_cov_s1[1]));
		sum_b = 9'(opbr_pkg::div255(prod_src_s1[2])) + 9'(opbr_pkg::div255(prod_cov_s1[2]));
		blend_pix.red   = sum_r[7:0];
		blend_pix.green = sum_g[7:0];
		blend_pix.blue  = sum_b[7:0];
	end

endmodule

>>> hdl/opbr_check.sv
`include "overlay_pixel_blend_restore_top_macros.svh"

module opbr_check (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       write_enable,
	input logic [7:0] write_x,
	input logic [7:0] write_y,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);

	logic fields_zero;

	assign fields_zero = (write_x == 8'd0) && (write_y == 8'd0) && (out_red == 8'd0)
		&& (out_green == 8'd0) && (out_blue == 8'd0);

	// a taken item keeps the block busy
	`OPBR_ASSERT_NEXT(a_take_busy, start && !busy, busy, "item taken but block not busy")

	// a result only follows a busy cycle
	`OPBR_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without an item in work")

	// results never come back to back
	`OPBR_ASSERT_NEXT(a_done_single, done, !done, "two results in a row")

	// no write means all fields zero
	`OPBR_ASSERT_SAME(a_nowrite_zero, done && !write_enable, fields_zero, "nonzero without write")

endmodule

bind overlay_pixel_blend_restore_top opbr_check u_opbr_check (.*);

>>> tb/sv/opbr_write_checker.sv
package opbr_tb_pkg;

	typedef enum logic {
		MODE_DRAW  = 1'b0,
		MODE_CLEAR = 1'b1
	} pixel_mode_t;

endpackage

module opbr_write_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            mode,
	input  logic [11:0]                     pos_x,
	input  logic [11:0]                     pos_y,
	input  logic [7:0]                      source_red,
	input  logic [7:0]                      source_green,
	input  logic [7:0]                      source_blue,
	input  logic [7:0]                      source_alpha,
	input  logic [7:0]                      buffer_red,
	input  logic [7:0]                      buffer_green,
	input  logic [7:0]                      buffer_blue,
	input  logic                            done,
	input  logic                            write_enable,
	input  logic [7:0]                      write_x,
	input  logic [7:0]                      write_y,
	input  logic [7:0]                      out_red,
	input  logic [7:0]                      out_green,
	input  logic [7:0]                      out_blue,
	input  logic                            cfg_write,
	input  logic [opbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [opbr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_PIXELS = opbr_pkg::FRAME_COLS_DEF * opbr_pkg::FRAME_ROWS_DEF;

	typedef struct packed {
		logic           enable;
		logic [7:0]     x;
		logic [7:0]     y;
		opbr_pkg::pix_t color;
	} pixel_write_t;

	opbr_pkg::pix_t drawn_mem [FRAME_PIXELS];
	opbr_pkg::pix_t saved_mem [FRAME_PIXELS];
	logic [8:0]     frame_w, frame_h;
	logic [11:0]    org_x, org_y, img_w, img_h;
	pixel_write_t   expected_writes [$];
	pixel_write_t   oldest;
	int             n_fail;

	function automatic bit frame_slot(input int fx, input int fy, output int idx);
		int fw, fh;
		fw = (int'(frame_w) > opbr_pkg::FRAME_COLS_DEF) ? opbr_pkg::FRAME_COLS_DEF
			: int'(frame_w);
		fh = (int'(frame_h) > opbr_pkg::FRAME_ROWS_DEF) ? opbr_pkg::FRAME_ROWS_DEF
			: int'(frame_h);
		idx = fy * opbr_pkg::FRAME_COLS_DEF + fx;
		return fx < fw && fy < fh;
	endfunction

	function automatic logic [7:0] blend_channel(input logic [7:0] s, input logic [7:0] c,
			input logic [7:0] a);
		return 8'((int'(s) * int'(a)) / 255 + (int'(c) * (255 - int'(a))) / 255);
	endfunction

	// if anything is saved, empties both stores; writes back only if the buffer still shows the drawn pixel
	function automatic pixel_write_t restore_pixel(input int fx, input int fy,
			input opbr_pkg::pix_t shown);
		pixel_write_t   w;
		int             idx;
		opbr_pkg::pix_t old;
		w = '0;
		if (!frame_slot(fx, fy, idx))
			return w;
		old = saved_mem[idx];
		if (old == '0)
			return w;
		if (drawn_mem[idx] == shown)
			w = '{1'b1, 8'(fx), 8'(fy), old};
		drawn_mem[idx] = '0;
		saved_mem[idx] = '0;
		return w;
	endfunction

	function automatic pixel_write_t composite(input logic m, input logic [11:0] px,
			input logic [11:0] py, input opbr_pkg::pix_t src, input logic [7:0] alpha,
			input opbr_pkg::pix_t shown);
		int             fx, fy, idx;
		opbr_pkg::pix_t pix, under;
		if (m == opbr_tb_pkg::MODE_CLEAR)
			return restore_pixel(int'(px), int'(py), shown);
		if (px >= img_w || py >= img_h)
			return '0;
		fx = int'(px) + int'(org_x);
		fy = int'(py) + int'(org_y);
		if (!frame_slot(fx, fy, idx))
			return '0;
		if (alpha == opbr_pkg::ALPHA_CLEAR)
			return restore_pixel(fx, fy, shown);
		pix = src;
		if (alpha != opbr_pkg::ALPHA_OPAQUE) begin
			// black in the save-under means nothing saved
			under = (saved_mem[idx] != '0) ? saved_mem[idx] : shown;
			pix.red   = blend_channel(src.red, under.red, alpha);
			pix.green = blend_channel(src.green, under.green, alpha);
			pix.blue  = blend_channel(src.blue, under.blue, alpha);
		end
		if (pix == shown)
			return '0;
		if (drawn_mem[idx] != shown)
			saved_mem[idx] = shown;
		drawn_mem[idx] = pix;
		return '{1'b1, 8'(fx), 8'(fy), pix};
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_fail++;
		end
	endfunction

	initial n_fail = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (drawn_mem[i]) begin
				drawn_mem[i] = '0;
				saved_mem[i] = '0;
			end
			frame_w = opbr_pkg::FRAME_SIZE_RST;
			frame_h = opbr_pkg::FRAME_SIZE_RST;
			org_x = '0;
			org_y = '0;
			img_w = '0;
			img_h = '0;
			expected_writes.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_writes.size() == 0) begin
					$error("write result with no item outstanding");
					n_fail++;
				end else begin
					oldest = expected_writes.pop_front();
					check_field("write_enable", {7'd0, oldest.enable}, {7'd0, write_enable});
					check_field("write_x", oldest.x, write_x);
					check_field("write_y", oldest.y, write_y);
					check_field("out_red", oldest.color.red, out_red);
					check_field("out_green", oldest.color.green, out_green);
					check_field("out_blue", oldest.color.blue, out_blue);
				end
			end
			if (start && !busy)
				expected_writes.push_back(composite(mode, pos_x, pos_y,
					{source_red, source_green, source_blue}, source_alpha,
					{buffer_red, buffer_green, buffer_blue}));
			if (cfg_write) begin
				unique case (cfg_index)
					opbr_pkg::REG_FRAME_WIDTH:  frame_w = cfg_data[8:0];
					opbr_pkg::REG_FRAME_HEIGHT: frame_h = cfg_data[8:0];
					opbr_pkg::REG_ORIGIN_X:     org_x = cfg_data;
					opbr_pkg::REG_ORIGIN_Y:     org_y = cfg_data;
					opbr_pkg::REG_IMAGE_WIDTH:  img_w = cfg_data;
					opbr_pkg::REG_IMAGE_HEIGHT: img_h = cfg_data;
					default: ;
				endcase
			end
			fail_count <= n_fail;
			outstanding <= expected_writes.size();
		end
	end

endmodule

>>> tb/sv/tb_overlay_pixel_blend_restore_top.sv
module tb_overlay_pixel_blend_restore_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [opbr_pkg::CFG_IDX_W-1:0] REG_ORDER [6] = '{
		opbr_pkg::REG_FRAME_WIDTH, opbr_pkg::REG_FRAME_HEIGHT,
		opbr_pkg::REG_ORIGIN_X, opbr_pkg::REG_ORIGIN_Y,
		opbr_pkg::REG_IMAGE_WIDTH, opbr_pkg::REG_IMAGE_HEIGHT};
	localparam opbr_pkg::pix_t PALETTE [4] = '{24'h000000, 24'hffffff, 24'h0000ff, 24'h80ff40};

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic                            mode;
	logic [11:0]                     pos_x, pos_y;
	logic [7:0]                      source_red, source_green, source_blue, source_alpha;
	logic [7:0]                      buffer_red, buffer_green, buffer_blue;
	logic                            done;
	logic                            write_enable;
	logic [7:0]                      write_x, write_y;
	logic [7:0]                      out_red, out_green, out_blue;
	logic                            cfg_write;
	logic [opbr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [opbr_pkg::CFG_DATA_W-1:0] cfg_data;
	int                              fail_count;
	int                              outstanding;

	opbr_pkg::pix_t frame_mem [opbr_pkg::FRAME_COLS_DEF * opbr_pkg::FRAME_ROWS_DEF];
	logic [11:0]    cur_ox, cur_oy, cur_iw, cur_ih;
	int             sent;

	overlay_pixel_blend_restore_top uut (.*);

	opbr_write_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	// frame buffer the block paints into; random items often read buffer values from it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame_mem[i])
				frame_mem[i] <= '0;
		end else if (done && write_enable) begin
			frame_mem[{write_y, write_x}] <= {out_red, out_green, out_blue};
		end
	end

	task automatic send_pixel(input opbr_tb_pkg::pixel_mode_t m, input logic [11:0] px,
			input logic [11:0] py, input opbr_pkg::pix_t src, input logic [7:0] alpha,
			input opbr_pkg::pix_t shown);
		start <= 1'b1;
		mode <= m;
		pos_x <= px;
		pos_y <= py;
		{source_red, source_green, source_blue} <= src;
		source_alpha <= alpha;
		{buffer_red, buffer_green, buffer_blue} <= shown;
		do
			@(posedge clk);
		while (busy);
		sent++;
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0 || busy);
	endtask

	task automatic load_settings(input int fw, input int fh, input int ox, input int oy,
			input int iw, input int ih);
		int vals [6];
		vals = '{fw, fh, ox, oy, iw, ih};
		foreach (vals[i]) begin
			cfg_write <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data <= opbr_pkg::CFG_DATA_W'(vals[i]);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		cur_ox = 12'(ox);
		cur_oy = 12'(oy);
		cur_iw = 12'(iw);
		cur_ih = 12'(ih);
	endtask

	// mostly a few pixels from the image corner, now and then right at or past the edge
	function automatic logic [11:0] near_edge(input logic [11:0] limit);
		int r;
		r = $urandom_range(0, 9);
		if (limit == 0 || r == 0)
			return 12'($urandom_range(0, 7));
		if (r == 1)
			return limit;
		if (r == 2)
			return limit - 12'd1;
		return 12'($urandom_range(0, (limit < 6 ? int'(limit) : 6) - 1));
	endfunction

	task automatic random_pixel();
		opbr_tb_pkg::pixel_mode_t m;
		logic [11:0]              px, py;
		logic [7:0]               alpha;
		int                       fx, fy;
		opbr_pkg::pix_t           src, shown;
		bit                       noise;
		noise = ($urandom_range(0, 99) < 20);
		m = ($urandom_range(0, 99) < 30) ? opbr_tb_pkg::MODE_CLEAR : opbr_tb_pkg::MODE_DRAW;
		if (noise) begin
			px = 12'($urandom_range(0, 4095));
			py = 12'($urandom_range(0, 4095));
		end else begin
			px = near_edge(cur_iw);
			py = near_edge(cur_ih);
			if (m == opbr_tb_pkg::MODE_CLEAR) begin
				px = px + cur_ox;
				py = py + cur_oy;
			end
		end
		fx = (m == opbr_tb_pkg::MODE_CLEAR) ? int'(px) : int'(px) + int'(cur_ox);
		fy = (m == opbr_tb_pkg::MODE_CLEAR) ? int'(py) : int'(py) + int'(cur_oy);
		case ($urandom_range(0, 7))
			0: alpha = opbr_pkg::ALPHA_CLEAR;
			1, 2, 3: alpha = opbr_pkg::ALPHA_OPAQUE;
			default: alpha = noise ? 8'($urandom) : 8'($urandom_range(1, 254));
		endcase
		src = ($urandom_range(0, 9) < 4) ? PALETTE[$urandom_range(0, 3)]
			: opbr_pkg::pix_t'(24'($urandom));
		if (!noise && fx < opbr_pkg::FRAME_COLS_DEF && fy < opbr_pkg::FRAME_ROWS_DEF
				&& $urandom_range(0, 3) != 0)
			shown = frame_mem[fy * opbr_pkg::FRAME_COLS_DEF + fx];
		else if ($urandom_range(0, 2) == 0)
			shown = '0;
		else
			shown = opbr_pkg::pix_t'(24'($urandom));
		send_pixel(m, px, py, src, alpha, shown);
	endtask

	task automatic run_phase(input int fw, input int fh, input int ox, input int oy,
			input int iw, input int ih, input int count);
		drain();
		load_settings(fw, fh, ox, oy, iw, ih);
		repeat (count) begin
			random_pixel();
			// a long stretch of back-to-back items in the middle of the run
			if ((sent < 900 || sent >= 1250) && $urandom_range(0, 99) < 29)
				pause($urandom_range(1, 8));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = opbr_tb_pkg::MODE_DRAW;
		pos_x = '0;
		pos_y = '0;
		source_red = '0;
		source_green = '0;
		source_blue = '0;
		source_alpha = '0;
		buffer_red = '0;
		buffer_green = '0;
		buffer_blue = '0;
		cfg_write = 1'b0;
		cfg_index = opbr_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		sent = 0;
		cur_ox = '0;
		cur_oy = '0;
		cur_iw = '0;
		cur_ih = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// 8x8 frame, 4x4 image at column 2, row 3
		run_phase(8, 8, 2, 3, 4, 4, 0);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 0, 0, 24'hffffff, opbr_pkg::ALPHA_OPAQUE, 24'h000000);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 1, 0, 24'h123456, opbr_pkg::ALPHA_OPAQUE, 24'ha0b0c0);
		send_pixel(opbr_tb_pkg::MODE_CLEAR, 3, 3, 24'h000000, opbr_pkg::ALPHA_CLEAR, 24'h123456);
		send_pixel(opbr_tb_pkg::MODE_CLEAR, 3, 3, 24'h000000, opbr_pkg::ALPHA_CLEAR, 24'ha0b0c0);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 2, 0, 24'h00ff00, opbr_pkg::ALPHA_OPAQUE, 24'h0000ff);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 2, 0, 24'h5a5a5a, opbr_pkg::ALPHA_CLEAR, 24'h00ff00);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 3, 0, 24'h111111, opbr_pkg::ALPHA_OPAQUE, 24'h222222);
		send_pixel(opbr_tb_pkg::MODE_CLEAR, 5, 3, 24'hffffff, opbr_pkg::ALPHA_OPAQUE, 24'h333333);
		send_pixel(opbr_tb_pkg::MODE_CLEAR, 5, 3, 24'h000000, opbr_pkg::ALPHA_CLEAR, 24'h111111);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 0, 1, 24'h000000, 8'h80, 24'h204060);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 0, 1, 24'hffffff, 8'h01, 24'hffffff);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 2, 1, 24'h445566, opbr_pkg::ALPHA_OPAQUE, 24'h445566);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 4, 0, 24'hffffff, opbr_pkg::ALPHA_OPAQUE, 24'h000000);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 0, 4, 24'hffffff, opbr_pkg::ALPHA_OPAQUE, 24'h000000);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 4095, 4095, 24'hffffff, opbr_pkg::ALPHA_OPAQUE,
			24'hffffff);
		send_pixel(opbr_tb_pkg::MODE_CLEAR, 4095, 4095, 24'hffffff, opbr_pkg::ALPHA_OPAQUE,
			24'hffffff);
		send_pixel(opbr_tb_pkg::MODE_CLEAR, 8, 3, 24'h000000, opbr_pkg::ALPHA_CLEAR, 24'h000000);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 3, 3, 24'hffffff, 8'hfe, 24'h000000);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 3, 2, 24'h000000, opbr_pkg::ALPHA_OPAQUE, 24'hffffff);

		// oversized frame saturates; image hangs over the bottom right corner
		run_phase(511, 300, 250, 252, 4095, 4095, 0);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 5, 3, 24'hffffff, opbr_pkg::ALPHA_OPAQUE, 24'h000000);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 6, 3, 24'hffffff, opbr_pkg::ALPHA_OPAQUE, 24'h000000);
		send_pixel(opbr_tb_pkg::MODE_CLEAR, 255, 255, 24'h000000, opbr_pkg::ALPHA_CLEAR,
			24'hffffff);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 5, 3, 24'h808080, opbr_pkg::ALPHA_OPAQUE, 24'h102030);
		send_pixel(opbr_tb_pkg::MODE_CLEAR, 255, 255, 24'h000000, opbr_pkg::ALPHA_CLEAR,
			24'h808080);

		// zero-size frame: nothing is inside
		run_phase(0, 0, 0, 0, 4, 4, 0);
		send_pixel(opbr_tb_pkg::MODE_DRAW, 0, 0, 24'hffffff, opbr_pkg::ALPHA_OPAQUE, 24'h000000);
		send_pixel(opbr_tb_pkg::MODE_CLEAR, 0, 0, 24'h000000, opbr_pkg::ALPHA_CLEAR, 24'hffffff);

		run_phase(8, 8, 0, 0, 8, 8, 400);
		run_phase(256, 256, 252, 250, 8, 8, 300);
		run_phase(511, 511, 0, 0, 4095, 4095, 300);
		run_phase(1, 1, 0, 0, 1, 1, 150);
		run_phase(300, 2, 3, 1, 5, 3, 300);
		run_phase(0, 0, 0, 0, 4, 4, 60);
		run_phase(256, 256, 4095, 4095, 2, 2, 40);
		run_phase($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(0, 260),
			$urandom_range(0, 260), $urandom_range(1, 12), $urandom_range(1, 12), 250);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
